// File: rtl/sh24_pkg.sv
// Shared types, constants and round functions for the SipHash-2-4 stream block.
// No dependencies; every rtl module refers to this package by scoped names.
package sh24_pkg;

  localparam logic [63:0] IV0        = 64'h736f6d6570736575;
  localparam logic [63:0] IV1        = 64'h646f72616e646f6d;
  localparam logic [63:0] IV2        = 64'h6c7967656e657261;
  localparam logic [63:0] IV3        = 64'h7465646279746573;
  localparam logic [63:0] FINAL_MARK = 64'h00000000000000ff;
  localparam int unsigned LEN_SHIFT  = 56;

  localparam int unsigned CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LOW  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_HIGH = 8'd1;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] v2;
    logic [63:0] v3;
  } chain_t;

  // One message handed from the front to the finalization pipeline.
  typedef struct packed {
    chain_t      chain;
    logic [63:0] tail;
  } fin_t;

  function automatic chain_t init_chain(input logic [63:0] kl, input logic [63:0] kh);
    chain_t s;
    s.v0 = IV0 ^ kl;
    s.v1 = IV1 ^ kh;
    s.v2 = IV2 ^ kl;
    s.v3 = IV3 ^ kh;
    return s;
  endfunction

  function automatic chain_t sip_round(input chain_t s);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
    chain_t      r;
    a = s.v0 + s.v1;
    b = {s.v1[50:0], s.v1[63:51]};   // rotl 13
    b = b ^ a;
    a = {a[31:0], a[63:32]};
    c = s.v2 + s.v3;
    d = {s.v3[47:0], s.v3[63:48]};   // rotl 16
    d = d ^ c;
    a = a + d;
    d = {d[42:0], d[63:43]};         // rotl 21
    d = d ^ a;
    c = c + b;
    b = {b[46:0], b[63:47]};         // rotl 17
    b = b ^ c;
    c = {c[31:0], c[63:32]};
    r.v0 = a;
    r.v1 = b;
    r.v2 = c;
    r.v3 = d;
    return r;
  endfunction

  function automatic chain_t double_round(input chain_t s);
    return sip_round(sip_round(s));
  endfunction

  function automatic chain_t absorb(input chain_t s, input logic [63:0] m);
    chain_t t;
    t    = s;
    t.v3 = t.v3 ^ m;
    t    = double_round(t);
    t.v0 = t.v0 ^ m;
    return t;
  endfunction

endpackage

// File: rtl/sh24_front.sv
// Front end: key registers, chain state and length; absorbs one word per beat.
// On the last beat it builds the tail word and hands chain plus tail to the queue.
// Depends on sh24_pkg.
module sh24_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [63:0]                         in_word,
  input  logic [3:0]                          in_bytes,
  input  logic                                in_last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sh24_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [63:0]                         cfg_data,
  output logic                                push,
  output sh24_pkg::fin_t                      push_data,
  input  logic                                queue_full
);

  logic [63:0]      key_low;
  logic [63:0]      key_high;
  logic [63:0]      key_low_next;
  logic [63:0]      key_high_next;
  logic             key_write;
  sh24_pkg::chain_t chain;
  sh24_pkg::chain_t absorbed;
  logic [7:0]       length_mod;
  logic [3:0]       nbytes;
  logic [7:0]       len_last;
  logic [63:0]      masked;
  logic             accept;

  assign in_ready  = !queue_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  always_comb begin
    key_low_next  = key_low;
    key_high_next = key_high;
    key_write     = 1'b0;
    if (cfg_valid) begin
      unique case (cfg_index)
        sh24_pkg::CFG_KEY_LOW: begin
          key_low_next = cfg_data;
          key_write    = 1'b1;
        end
        sh24_pkg::CFG_KEY_HIGH: begin
          key_high_next = cfg_data;
          key_write     = 1'b1;
        end
        default: key_write = 1'b0;
      endcase
    end
  end

  // counts above 8 saturate
  assign nbytes   = in_bytes[3] ? 4'd8 : in_bytes;
  assign len_last = length_mod + {4'd0, nbytes};
  assign absorbed = sh24_pkg::absorb(chain, in_word);

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      masked[8*i +: 8] = (4'(i) < nbytes) ? in_word[8*i +: 8] : 8'd0;
    end
  end

  always_comb begin
    push_data.chain = nbytes[3] ? absorbed : chain;
    push_data.tail  = (nbytes[3] ? 64'd0 : masked)
                    | ({56'd0, len_last} << sh24_pkg::LEN_SHIFT);
  end

  assign push = accept && in_last && !key_write;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low    <= 64'd0;
      key_high   <= 64'd0;
      chain      <= sh24_pkg::init_chain(64'd0, 64'd0);
      length_mod <= 8'd0;
    end else if (key_write) begin
      key_low    <= key_low_next;
      key_high   <= key_high_next;
      chain      <= sh24_pkg::init_chain(key_low_next, key_high_next);
      length_mod <= 8'd0;
    end else if (accept) begin
      if (in_last) begin
        chain      <= sh24_pkg::init_chain(key_low, key_high);
        length_mod <= 8'd0;
      end else begin
        chain      <= absorbed;
        length_mod <= length_mod + 8'd8;
      end
    end
  end

endmodule

// File: rtl/sh24_queue.sv
// Short register queue of finished-absorb messages between front and back.
// Depends on sh24_pkg.
module sh24_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sh24_pkg::fin_t push_data,
  output logic           full,
  output logic           head_valid,
  output sh24_pkg::fin_t head_data,
  input  logic           pop
);

  localparam int unsigned AW = sh24_pkg::QUEUE_AW;

  sh24_pkg::fin_t entries [sh24_pkg::QUEUE_DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [AW:0]    count;
  logic           do_pop;

  assign full       = (count == (AW+1)'(sh24_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = entries[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/sh24_back.sv
// Finalization pipeline: tail absorb, then four rounds over the next two stages,
// the second being the output register. Stalls stage by stage. Depends on sh24_pkg.
module sh24_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  sh24_pkg::fin_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [63:0]    out_hash
);

  sh24_pkg::chain_t s1_chain;
  sh24_pkg::chain_t s2_chain;
  sh24_pkg::chain_t s1_calc;
  sh24_pkg::chain_t s3_calc;
  logic             s1_valid;
  logic             s2_valid;
  logic             adv_out;
  logic             adv2;
  logic             adv1;

  assign adv_out  = !out_valid || out_ready;
  assign adv2     = !s2_valid || adv_out;
  assign adv1     = !s1_valid || adv2;
  assign in_ready = adv1;

  always_comb begin
    s1_calc    = sh24_pkg::absorb(in_data.chain, in_data.tail);
    s1_calc.v2 = s1_calc.v2 ^ sh24_pkg::FINAL_MARK;
  end

  assign s3_calc = sh24_pkg::double_round(s2_chain);

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_chain <= s1_calc;
    end
    if (adv2) begin
      s2_chain <= sh24_pkg::double_round(s1_chain);
    end
    if (adv_out) begin
      out_hash <= (s3_calc.v0 ^ s3_calc.v1) ^ (s3_calc.v2 ^ s3_calc.v3);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv1) begin
        s1_valid <= in_valid;
      end
      if (adv2) begin
        s2_valid <= s1_valid;
      end
      if (adv_out) begin
        out_valid <= s2_valid;
      end
    end
  end

endmodule

// File: rtl/siphash_2_4_stream.sv
// Streaming SipHash-2-4: one 64-bit message word per cycle when not stalled, one hash per message.
// After the last beat is taken, the message is registered in the queue entry, the tail absorb
// stage, two finalization rounds into stage 2 and two more rounds into the output register.
// Throughput: one beat per cycle while the queue has room, set by the two-round absorb in the front.
// Reset: keys clear to zero, chain loads the initial constants, queue and
// pipeline empty. Depends on sh24_pkg, sh24_front, sh24_queue, sh24_back.
module siphash_2_4_stream (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [71:0]                      s_tdata,  // message_word[63:0], valid_bytes[67:64], zero pad
  input  logic                             s_tlast,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [63:0]                      m_tdata,  // hash_value[63:0]
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sh24_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]                      cfg_data
);

  logic           push;
  sh24_pkg::fin_t push_data;
  logic           queue_full;
  logic           head_valid;
  sh24_pkg::fin_t head_data;
  logic           back_ready;

  sh24_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_word    (s_tdata[63:0]),
    .in_bytes   (s_tdata[67:64]),
    .in_last    (s_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .push_data  (push_data),
    .queue_full (queue_full)
  );

  sh24_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (back_ready)
  );

  sh24_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (head_valid),
    .in_ready  (back_ready),
    .in_data   (head_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_hash  (m_tdata)
  );

endmodule
